[design/fcps_pkg.sv]
package fcps_pkg;

  localparam int COORD_BITS          = 12;
  localparam int DIM_BITS            = 12;
  localparam int COLOR_BITS          = 8;
  localparam int RADIUS_BITS         = 3;
  localparam int INDEX_BITS          = 24;
  localparam int CFG_INDEX_BITS      = 3;
  localparam int CFG_DATA_BITS       = 12;
  localparam int MAX_PEN_RADIUS_DEF  = 4;
  localparam int JOB_QUEUE_DEPTH     = 2;

  localparam logic [DIM_BITS-1:0]    WIDTH_RESET  = 12'd500;
  localparam logic [DIM_BITS-1:0]    HEIGHT_RESET = 12'd400;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 3'd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PEN_RED      = 3'd2,
    REG_PEN_GREEN    = 3'd3,
    REG_PEN_BLUE     = 3'd4,
    REG_PEN_RADIUS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] pixel_index;
    logic [COLOR_BITS-1:0] out_red;
    logic [COLOR_BITS-1:0] out_green;
    logic [COLOR_BITS-1:0] out_blue;
    logic                  last_write;
  } out_word_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]    image_width;
    logic [DIM_BITS-1:0]    image_height;
    logic [COLOR_BITS-1:0]  pen_red;
    logic [COLOR_BITS-1:0]  pen_green;
    logic [COLOR_BITS-1:0]  pen_blue;
    logic [RADIUS_BITS-1:0] pen_radius;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius;
  } job_t;

  typedef struct packed {
    logic       push;
    logic [1:0] fill;
  } front_sts_t;

endpackage

[design/fcps_front.sv]
module fcps_front #(
  parameter int MAX_PEN_RADIUS = fcps_pkg::MAX_PEN_RADIUS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  fcps_pkg::in_word_t   in_data,
  input  fcps_pkg::cfg_t       cfg,
  output logic                 busy,
  output logic                 job_valid,
  output fcps_pkg::job_t       job,
  input  logic                 job_pop,
  output fcps_pkg::front_sts_t sts
);

  localparam logic [1:0] FULL_CNT = 2'(fcps_pkg::JOB_QUEUE_DEPTH);

  fcps_pkg::job_t                         queue_r [fcps_pkg::JOB_QUEUE_DEPTH];
  logic                                   wr_ptr_r, wr_ptr_nxt;
  logic                                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                             cnt_r, cnt_nxt;
  logic                                   accept;
  logic                                   push;
  logic [fcps_pkg::RADIUS_BITS-1:0]       rad_clamped;
  fcps_pkg::job_t                         new_job;

  assign busy      = (cnt_r == FULL_CNT);
  assign accept    = start && !busy;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = queue_r[rd_ptr_r];

  // zero radius or empty frame gives no writes, so the centre is dropped here
  assign push = accept && (cfg.pen_radius != '0) && (cfg.image_width != '0)
                && (cfg.image_height != '0);

  assign rad_clamped = (cfg.pen_radius > fcps_pkg::RADIUS_BITS'(MAX_PEN_RADIUS)) ?
                       fcps_pkg::RADIUS_BITS'(MAX_PEN_RADIUS) : cfg.pen_radius;

  always_comb begin
    new_job.center_x = in_data.center_x;
    new_job.center_y = in_data.center_y;
    new_job.radius   = rad_clamped;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (job_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !job_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && job_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_job;
    end
  end

  always_comb begin
    sts.push = push;
    sts.fill = cnt_r;
  end

endmodule

[design/fcps_back.sv]
module fcps_back #(
  parameter int MAX_PEN_RADIUS = fcps_pkg::MAX_PEN_RADIUS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcps_pkg::cfg_t      cfg,
  input  logic                job_valid,
  input  fcps_pkg::job_t      job,
  output logic                job_pop,
  output logic                out_strobe,
  output fcps_pkg::out_word_t out_data
);

  localparam int RM_W  = (MAX_PEN_RADIUS > 1) ? $clog2(MAX_PEN_RADIUS) : 1;
  localparam int OFF_W = RM_W + 1;
  localparam int R_W   = $clog2(MAX_PEN_RADIUS + 1);
  localparam int SQ_W  = 2 * R_W + 2;
  localparam int XW    = fcps_pkg::COORD_BITS + 2;
  localparam int PW    = XW + fcps_pkg::DIM_BITS + 1;
  localparam int IW    = PW + 1;
  localparam int LW    = 2 * fcps_pkg::DIM_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_END  = 3'b100
  } scan_state_t;

  scan_state_t                        state_r, state_nxt;
  logic [fcps_pkg::COORD_BITS-1:0]    cx_r, cy_r;
  logic [RM_W-1:0]                    rm1_r, rm1_new;
  logic [R_W-1:0]                     rad_r;
  logic signed [OFF_W-1:0]            dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [OFF_W-1:0]            lo, hi, lo_new;

  logic signed [SQ_W-1:0]             dxw, dyw, dsq, rsq;
  logic signed [XW-1:0]               x0, y0;

  logic                               v1_r, e1_r, in1_r;
  logic signed [XW-1:0]               x1_r, y1_r;
  logic                               v2_r, e2_r, in2_r;
  logic signed [XW-1:0]               x2_r;
  logic signed [PW-1:0]               prod2_r;
  logic signed [fcps_pkg::DIM_BITS:0] w_ext;
  logic [LW-1:0]                      limit_r;

  logic signed [IW-1:0]               idx;
  logic                               kept;
  logic                               pend_v_r, pend_v_nxt;
  logic [fcps_pkg::INDEX_BITS-1:0]    pend_idx_r;
  logic                               emit, emit_last;

  assign lo      = -$signed({1'b0, rm1_r});
  assign hi      = $signed({1'b0, rm1_r});
  assign rm1_new = RM_W'(job.radius - 1'b1);
  assign lo_new  = -$signed({1'b0, rm1_new});
  assign job_pop = (state_r == S_IDLE) && job_valid;

  // scan the square of offsets that holds every one that can pass the distance test, dx outer
  always_comb begin
    state_nxt = state_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          state_nxt = S_SCAN;
          dx_nxt    = lo_new;
          dy_nxt    = lo_new;
        end
      end
      S_SCAN: begin
        if (dy_r == hi) begin
          dy_nxt = lo;
          if (dx_r == hi) begin
            state_nxt = S_END;
          end else begin
            dx_nxt = dx_r + 1'b1;
          end
        end else begin
          dy_nxt = dy_r + 1'b1;
        end
      end
      S_END: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    if (job_pop) begin
      cx_r  <= job.center_x;
      cy_r  <= job.center_y;
      rm1_r <= rm1_new;
      rad_r <= R_W'(job.radius);
    end
  end

  // stage 0: distance test and absolute coordinates
  assign dxw = SQ_W'(dx_r);
  assign dyw = SQ_W'(dy_r);
  assign dsq = dxw * dxw + dyw * dyw;
  assign rsq = $signed(SQ_W'(rad_r)) * $signed(SQ_W'(rad_r));
  assign x0  = $signed(XW'(cx_r)) + XW'(dx_r);
  assign y0  = $signed(XW'(cy_r)) + XW'(dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      e1_r <= 1'b0;
      v2_r <= 1'b0;
      e2_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_SCAN);
      e1_r <= (state_r == S_END);
      v2_r <= v1_r;
      e2_r <= e1_r;
    end
  end

  // stage 1: row offset y * width
  assign w_ext = $signed({1'b0, cfg.image_width});

  always_ff @(posedge clk) begin
    in1_r   <= (dsq < rsq);
    x1_r    <= x0;
    y1_r    <= y0;
    in2_r   <= in1_r;
    x2_r    <= x1_r;
    prod2_r <= PW'(y1_r * w_ext);
    limit_r <= cfg.image_width * cfg.image_height;
  end

  // stage 2: bounds check on the linear index
  assign idx  = IW'(x2_r) + IW'(prod2_r);
  assign kept = v2_r && in2_r && !idx[IW-1] && (idx[IW-2:0] < (IW-1)'(limit_r));

  // one kept point is held back so the final write can carry the last flag
  always_comb begin
    emit       = 1'b0;
    emit_last  = 1'b0;
    pend_v_nxt = pend_v_r;
    if (kept) begin
      emit       = pend_v_r;
      pend_v_nxt = 1'b1;
    end else if (e2_r) begin
      emit       = pend_v_r;
      emit_last  = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      pend_v_r   <= pend_v_nxt;
      out_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (kept) begin
      pend_idx_r <= idx[fcps_pkg::INDEX_BITS-1:0];
    end
    if (emit) begin
      out_data.pixel_index <= pend_idx_r;
      out_data.out_red     <= cfg.pen_red;
      out_data.out_green   <= cfg.pen_green;
      out_data.out_blue    <= cfg.pen_blue;
      out_data.last_write  <= emit_last;
    end
  end

endmodule

[design/filled_circle_pixel_stamp.sv]
// filled disc stamp: one pen centre in, a burst of frame-buffer writes out
// input: present in_data with start; the centre is taken on a clock edge
//   where start is high and busy is low. up to two centres queue up while
//   an earlier one is still being drawn; busy is high while the queue is full
// output: each write appears on out_data for one cycle with out_strobe high;
//   the receiver cannot stall, every strobe is a delivered word. the last
//   word of a centre has last_write set; a centre fully out of bounds, a zero
//   radius or an empty frame gives no words at all
// config: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//   write only while no centre is in flight. unknown indexes are ignored
// timing: the scanner walks the (2r-1)^2 offsets of the disc box, one per
//   cycle, then passes through S_END to close the centre and S_IDLE to
//   pick up the next. a word passes the stage 1 and stage 2 registers and
//   the output register, and is held back in between until the next kept
//   point or the end of the centre is known
// reset: synchronous, active low; clears the queue, the scanner and the
//   registers to width 500, height 400, black pen, radius 1. no clearing pass
module filled_circle_pixel_stamp #(
  parameter int MAX_PEN_RADIUS = fcps_pkg::MAX_PEN_RADIUS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  fcps_pkg::in_word_t                     in_data,
  output logic                                   out_strobe,
  output fcps_pkg::out_word_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fcps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [fcps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  fcps_pkg::cfg_t       cfg_r;
  fcps_pkg::job_t       job;
  logic                 job_valid;
  logic                 job_pop;
  fcps_pkg::front_sts_t front_sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= fcps_pkg::WIDTH_RESET;
      cfg_r.image_height <= fcps_pkg::HEIGHT_RESET;
      cfg_r.pen_red      <= '0;
      cfg_r.pen_green    <= '0;
      cfg_r.pen_blue     <= '0;
      cfg_r.pen_radius   <= fcps_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (fcps_pkg::cfg_reg_t'(cfg_index))
        fcps_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        fcps_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        fcps_pkg::REG_PEN_RED:      cfg_r.pen_red      <= cfg_data[fcps_pkg::COLOR_BITS-1:0];
        fcps_pkg::REG_PEN_GREEN:    cfg_r.pen_green    <= cfg_data[fcps_pkg::COLOR_BITS-1:0];
        fcps_pkg::REG_PEN_BLUE:     cfg_r.pen_blue     <= cfg_data[fcps_pkg::COLOR_BITS-1:0];
        fcps_pkg::REG_PEN_RADIUS:   cfg_r.pen_radius   <= cfg_data[fcps_pkg::RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  fcps_front #(
    .MAX_PEN_RADIUS(MAX_PEN_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .busy      (busy),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .sts       (front_sts)
  );

  fcps_back #(
    .MAX_PEN_RADIUS(MAX_PEN_RADIUS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // a queued centre cannot vanish in the same edge it was written
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    front_sts.push |=> (front_sts.fill != 2'd0))
    else $error("queue empty right after a push");

  // the last word of a centre is never followed directly by another word
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last_write) |=> !out_strobe)
    else $error("word strobed right after a last word");

  // the queue never reports more entries than it holds
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_sts.fill != 2'd3)
    else $error("queue fill out of range");

endmodule

[dv/filled_circle_pixel_stamp_test.sv]
`timescale 1ns / 1ps

module filled_circle_pixel_stamp_test;

  localparam int MAX_R = fcps_pkg::MAX_PEN_RADIUS_DEF;
  // up to a queue full of centres plus the one being scanned, all at full radius
  localparam int SETTLE_CYCLES =
    (fcps_pkg::JOB_QUEUE_DEPTH + 1) * ((2 * MAX_R - 1) ** 2 + 2) + 16;
  localparam int NUM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int PRINT_LIMIT = 40;

  // register indexes with nothing behind them
  localparam logic [fcps_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [fcps_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PEN,
    ROW_PEN_ONE,
    ROW_PEN_NONE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [11:0]                     a;
    logic [11:0]                     b;
    logic [fcps_pkg::INDEX_BITS-1:0] exp_index;
  } stim_row_t;

  localparam int NUM_ROWS = 48;

  // cfg rows: a = register, b = data; pen rows: a = x, b = y
  stim_row_t script [0:NUM_ROWS-1] = '{
    '{ROW_PEN_ONE,  12'd0,    12'd0,    24'd0},
    '{ROW_PEN_ONE,  12'd499,  12'd399,  24'd199999},
    '{ROW_PEN_ONE,  12'd0,    12'd399,  24'd199500},
    '{ROW_PEN_ONE,  12'd499,  12'd0,    24'd499},
    '{ROW_PEN_NONE, 12'd500,  12'd399,  24'd0},
    '{ROW_PEN_NONE, 12'd4095, 12'd4095, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RED),      12'h0FF, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_GREEN),    12'hF5A, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_BLUE),     12'h000, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_WIDTH),  12'd4095, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_HEIGHT), 12'd4095, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RADIUS),   12'd4, 24'd0},
    '{ROW_PEN,      12'd0,    12'd0,    24'd0},
    '{ROW_PEN,      12'd4095, 12'd4095, 24'd0},
    '{ROW_PEN,      12'd2048, 12'd2047, 24'd0},
    '{ROW_PEN,      12'd4095, 12'd0,    24'd0},
    '{ROW_PEN,      12'd0,    12'd4095, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RADIUS),   12'd0, 24'd0},
    '{ROW_PEN_NONE, 12'd100,  12'd100,  24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RADIUS),   12'd7, 24'd0},
    '{ROW_PEN,      12'd10,   12'd10,   24'd0},
    '{ROW_PEN,      12'd4095, 12'd4095, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_WIDTH),  12'd0, 24'd0},
    '{ROW_PEN_NONE, 12'd5,    12'd5,    24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_WIDTH),  12'd3, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_HEIGHT), 12'd2, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RADIUS),   12'd2, 24'd0},
    '{ROW_PEN,      12'd1,    12'd1,    24'd0},
    '{ROW_PEN,      12'd2,    12'd0,    24'd0},
    '{ROW_PEN,      12'd0,    12'd1,    24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_HEIGHT), 12'd0, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_WIDTH),  12'd4095, 24'd0},
    '{ROW_PEN_NONE, 12'd0,    12'd0,    24'd0},
    '{ROW_CFG, 12'(REG_UNMAPPED_LO),  12'hFFF, 24'd0},
    '{ROW_CFG, 12'(REG_UNMAPPED_HI),  12'h123, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_HEIGHT), 12'd1, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RADIUS),   12'd3, 24'd0},
    '{ROW_PEN,      12'd100,  12'd0,    24'd0},
    '{ROW_PEN,      12'd4094, 12'd0,    24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_WIDTH),  12'd1, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_IMAGE_HEIGHT), 12'd4095, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RADIUS),   12'd4, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_BLUE),     12'hFFF, 24'd0},
    '{ROW_PEN,      12'd0,    12'd2000, 24'd0},
    '{ROW_PEN,      12'd1,    12'd4094, 24'd0},
    '{ROW_CFG, 12'(fcps_pkg::REG_PEN_RED),      12'h000, 24'd0},
    '{ROW_PEN,      12'd0,    12'd4095, 24'd0},
    '{ROW_PEN,      12'd2,    12'd0,    24'd0}
  };

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  fcps_pkg::in_word_t                  in_data = '0;
  logic                                out_strobe;
  fcps_pkg::out_word_t                 out_data;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [fcps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [fcps_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // shadow copy of the block's registers
  logic [fcps_pkg::DIM_BITS-1:0]    img_width = fcps_pkg::WIDTH_RESET;
  logic [fcps_pkg::DIM_BITS-1:0]    img_height = fcps_pkg::HEIGHT_RESET;
  logic [fcps_pkg::COLOR_BITS-1:0]  pen_red = '0;
  logic [fcps_pkg::COLOR_BITS-1:0]  pen_green = '0;
  logic [fcps_pkg::COLOR_BITS-1:0]  pen_blue = '0;
  logic [fcps_pkg::RADIUS_BITS-1:0] pen_radius = fcps_pkg::RADIUS_RESET;

  fcps_pkg::out_word_t writes_due [$];
  fcps_pkg::out_word_t due_word;
  int                  mismatch_count = 0;

  filled_circle_pixel_stamp i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // disc writes for one centre, x outer, y inner
  function automatic void predict_stamp(fcps_pkg::in_word_t pen);
    longint              cx, cy, r, w, lim, x, y, dx, dy, idx;
    int                  cnt;
    fcps_pkg::out_word_t wr;
    cx = pen.center_x;
    cy = pen.center_y;
    r = (pen_radius > MAX_R) ? MAX_R : pen_radius;
    w = img_width;
    lim = longint'(img_width) * longint'(img_height);
    cnt = 0;
    for (x = cx - r; x < cx + 2 * r; x++) begin
      for (y = cy - r; y < cy + 2 * r; y++) begin
        dx = x - cx;
        dy = y - cy;
        idx = x + y * w;
        if (dx * dx + dy * dy < r * r && idx >= 0 && idx < lim && cnt < 64) begin
          wr.pixel_index = idx[fcps_pkg::INDEX_BITS-1:0];
          wr.out_red = pen_red;
          wr.out_green = pen_green;
          wr.out_blue = pen_blue;
          wr.last_write = 1'b0;
          writes_due.push_back(wr);
          cnt++;
        end
      end
    end
    if (cnt > 0) begin
      writes_due[writes_due.size() - 1].last_write = 1'b1;
    end
  endfunction

  function automatic void apply_reg(logic [fcps_pkg::CFG_INDEX_BITS-1:0] idx,
                                    logic [fcps_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      fcps_pkg::REG_IMAGE_WIDTH:  img_width = data[fcps_pkg::DIM_BITS-1:0];
      fcps_pkg::REG_IMAGE_HEIGHT: img_height = data[fcps_pkg::DIM_BITS-1:0];
      fcps_pkg::REG_PEN_RED:      pen_red = data[fcps_pkg::COLOR_BITS-1:0];
      fcps_pkg::REG_PEN_GREEN:    pen_green = data[fcps_pkg::COLOR_BITS-1:0];
      fcps_pkg::REG_PEN_BLUE:     pen_blue = data[fcps_pkg::COLOR_BITS-1:0];
      fcps_pkg::REG_PEN_RADIUS:   pen_radius = data[fcps_pkg::RADIUS_BITS-1:0];
      default: ;
    endcase
  endfunction

  // leaves cfg_valid high so back-to-back writes need no re-raise
  task automatic write_reg(logic [fcps_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [fcps_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic send_pen(fcps_pkg::in_word_t pen, row_kind_t kind,
                          logic [fcps_pkg::INDEX_BITS-1:0] exp_index);
    fcps_pkg::out_word_t wr;
    start <= 1'b1;
    in_data <= pen;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == ROW_PEN) begin
      predict_stamp(pen);
    end else if (kind == ROW_PEN_ONE) begin
      wr = '{pixel_index: exp_index, out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0,
             last_write: 1'b1};
      writes_due.push_back(wr);
    end
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // stop sending, wait out every expected word, optionally let empty centres finish
  task automatic wait_drained(bit settle);
    start <= 1'b0;
    @(posedge clk);
    while (writes_due.size() != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (writes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word, index %0d", out_data.pixel_index));
      end else begin
        due_word = writes_due.pop_front();
        if (out_data.pixel_index !== due_word.pixel_index)
          report_mismatch($sformatf("pixel_index %0d, want %0d",
                                    out_data.pixel_index, due_word.pixel_index));
        if (out_data.out_red !== due_word.out_red)
          report_mismatch($sformatf("out_red %h, want %h at index %0d",
                                    out_data.out_red, due_word.out_red, due_word.pixel_index));
        if (out_data.out_green !== due_word.out_green)
          report_mismatch($sformatf("out_green %h, want %h at index %0d",
                                    out_data.out_green, due_word.out_green,
                                    due_word.pixel_index));
        if (out_data.out_blue !== due_word.out_blue)
          report_mismatch($sformatf("out_blue %h, want %h at index %0d",
                                    out_data.out_blue, due_word.out_blue, due_word.pixel_index));
        if (out_data.last_write !== due_word.last_write)
          report_mismatch($sformatf("last_write %b, want %b at index %0d",
                                    out_data.last_write, due_word.last_write,
                                    due_word.pixel_index));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int                 i, ph, k, w, h, r, hx, hy;
    bit                 cfg_open, burst;
    stim_row_t          row;
    fcps_pkg::in_word_t pen;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_open = 1'b0;
    for (i = 0; i < NUM_ROWS; i++) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) wait_drained(1'b1);
        write_reg(row.a[fcps_pkg::CFG_INDEX_BITS-1:0], row.b);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        pen.center_x = row.a;
        pen.center_y = row.b;
        send_pen(pen, row.kind, row.exp_index);
        idle_gap(pick_gap());
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained(1'b1);
      // fixed extremes first, then random frames mixing tiny and full size
      case (ph)
        0: begin w = 4095; h = 4095; r = MAX_R; end
        1: begin w = 1;    h = 4095; r = $urandom_range(1, MAX_R); end
        2: begin w = 4095; h = 1;    r = $urandom_range(1, MAX_R); end
        3: begin w = 1;    h = 1;    r = $urandom_range(1, 7); end
        default: begin
          w = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 4095);
          h = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, 4095);
          r = ($urandom_range(0, 99) < 85) ? $urandom_range(1, MAX_R) : $urandom_range(0, 7);
        end
      endcase
      write_reg(fcps_pkg::REG_IMAGE_WIDTH, 12'(w));
      write_reg(fcps_pkg::REG_PEN_RED, 12'($urandom_range(0, 4095)));
      write_reg(fcps_pkg::REG_IMAGE_HEIGHT, 12'(h));
      write_reg(fcps_pkg::REG_PEN_GREEN, 12'($urandom_range(0, 4095)));
      write_reg(fcps_pkg::REG_PEN_BLUE, 12'($urandom_range(0, 4095)));
      // upper data bits are don't-care for the radius
      write_reg(fcps_pkg::REG_PEN_RADIUS, {9'($urandom), 3'(r)});
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  12'($urandom_range(0, 4095)));
      end
      cfg_valid <= 1'b0;

      burst = ($urandom_range(0, 3) == 0);
      hx = (w + 3 > 4095) ? 4095 : w + 3;
      hy = (h + 3 > 4095) ? 4095 : h + 3;
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2 && ph % 2 == 1) wait_drained(1'b0);
        if ($urandom_range(0, 99) < 80) begin
          pen.center_x = 12'($urandom_range(0, hx));
          pen.center_y = 12'($urandom_range(0, hy));
        end else begin
          pen.center_x = 12'($urandom_range(0, 4095));
          pen.center_y = 12'($urandom_range(0, 4095));
        end
        send_pen(pen, ROW_PEN, '0);
        idle_gap(burst ? 0 : pick_gap());
      end
    end

    wait_drained(1'b1);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filled_circle_pixel_stamp.f]
design/fcps_pkg.sv
design/fcps_front.sv
design/fcps_back.sv
design/filled_circle_pixel_stamp.sv
dv/filled_circle_pixel_stamp_test.sv
